### rtl/qos_pkg.sv
// Package: shared types and constants of the queue of stacks manager.
`timescale 1ns / 1ps

package qos_pkg;

  // Fixed field widths of the command and response channels
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SIZE_W   = 5;
  localparam int unsigned QLEN_W   = 3;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PARK = 2'd2,
    CMD_TAKE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_STACK_EMPTY = 2'd1,
    STS_QUEUE_EMPTY = 2'd2,
    STS_FULL        = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the transaction and launch memory reads
    logic execute;  // apply the command and load the result register
  } ctl_t;

endpackage

### rtl/qos_if.sv
// Interfaces: command and response channels with valid/ready handshake.
`timescale 1ns / 1ps

interface qos_req_if;
  logic                                valid;
  logic                                ready;
  qos_pkg::cmd_e                       cmd;
  logic signed [qos_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface qos_rsp_if;
  logic                                valid;
  logic                                ready;
  qos_pkg::status_e                    status;
  logic signed [qos_pkg::VALUE_W-1:0]  popped_value;
  logic [qos_pkg::SIZE_W-1:0]          stack_size;
  logic [qos_pkg::QLEN_W-1:0]          queue_length;

  modport source (output valid, output status, output popped_value, output stack_size,
                  output queue_length, input ready);
  modport sink   (input valid, input status, input popped_value, input stack_size,
                  input queue_length, output ready);
endinterface

### rtl/qos_ctrl.sv
// Controller: sequences capture and execute of each command, owns result valid.
`timescale 1ns / 1ps

module qos_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qos_pkg::ctl_t ctl_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // Commands to the datapath
  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    ctl_o.capture   = (state_q == ST_IDLE) && in_valid_i;
    ctl_o.execute   = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EXEC;
          if (out_ready_i) out_valid_q <= 1'b0;
        end
        ST_EXEC: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/qos_dpath.sv
// Datapath: slot word memory, queue ring, pointers, free map and result register.
`timescale 1ns / 1ps

module qos_dpath #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned NUM_SLOTS   = 8,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  qos_pkg::ctl_t                      ctl_i,
  input  qos_pkg::cmd_e                      cmd_i,
  input  logic signed [qos_pkg::VALUE_W-1:0] value_i,
  output qos_pkg::status_e                   status_o,
  output logic signed [qos_pkg::VALUE_W-1:0] popped_value_o,
  output logic [qos_pkg::SIZE_W-1:0]         stack_size_o,
  output logic [qos_pkg::QLEN_W-1:0]         queue_length_o
);

  localparam int unsigned SW  = $clog2(NUM_SLOTS);
  localparam int unsigned CW  = $clog2(NUM_SLOTS);
  localparam int unsigned DIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned FW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VW  = qos_pkg::VALUE_W;
  localparam logic [FW-1:0] FILL_MAX  = FW'(STACK_DEPTH);
  localparam logic [CW:0]   SLOTS_EXT = (CW + 1)'(NUM_SLOTS);
  localparam logic [CW-1:0] HEAD_LAST = CW'(NUM_SLOTS - 1);

  // Memories
  logic [DATA_WIDTH-1:0] words_mem [NUM_SLOTS][STACK_DEPTH];
  logic [SW-1:0]         ring_slot_mem [NUM_SLOTS];
  logic [FW-1:0]         ring_fill_mem [NUM_SLOTS];

  // Architectural state
  logic [SW-1:0]        work_slot_q, work_slot_d;
  logic [FW-1:0]        work_fill_q, work_fill_d;
  logic [CW-1:0]        head_q, head_d;
  logic [CW-1:0]        count_q, count_d;
  logic [NUM_SLOTS-1:0] free_q, free_d;

  // Captured transaction and read data
  qos_pkg::cmd_e         cmd_q;
  logic [VW-1:0]         value_q;
  logic [DATA_WIDTH-1:0] rd_word_q;
  logic [SW-1:0]         rd_slot_q;
  logic [FW-1:0]         rd_fill_q;

  // Result register
  qos_pkg::status_e  status_q, status_d;
  logic [VW-1:0]     popped_q, popped_d;
  logic [qos_pkg::SIZE_W-1:0] size_q;
  logic [qos_pkg::QLEN_W-1:0] qlen_q;

  logic [DIW-1:0]             rd_idx;
  logic [SW-1:0]              fresh;
  logic [CW:0]                tail_sum;
  logic [CW-1:0]              tail;
  logic [DATA_WIDTH+VW-1:0]   value_ext;
  logic [DATA_WIDTH+VW-1:0]   word_sx;
  logic [FW+qos_pkg::SIZE_W-1:0] size_ext;
  logic [CW+qos_pkg::QLEN_W-1:0] qlen_ext;
  logic                       word_we;
  logic                       ring_we;

  // Read address of the top word; an empty stack reads entry zero, unused
  assign rd_idx = (work_fill_q == '0) ? '0 : DIW'(work_fill_q - FW'(1));

  // Lowest free slot
  always_comb begin
    fresh = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (free_q[i]) fresh = SW'(i);
    end
  end

  // Ring tail = (head + count) mod slots
  always_comb begin
    tail_sum = {1'b0, head_q} + {1'b0, count_q};
    if (tail_sum >= SLOTS_EXT) tail_sum = tail_sum - SLOTS_EXT;
    tail = tail_sum[CW-1:0];
  end

  assign value_ext = {{DATA_WIDTH{1'b0}}, value_q};
  assign word_sx   = {{VW{rd_word_q[DATA_WIDTH-1]}}, rd_word_q};

  // Command execution
  always_comb begin
    work_slot_d = work_slot_q;
    work_fill_d = work_fill_q;
    head_d      = head_q;
    count_d     = count_q;
    free_d      = free_q;
    status_d    = qos_pkg::STS_OK;
    popped_d    = '0;
    word_we     = 1'b0;
    ring_we     = 1'b0;
    unique case (cmd_q)
      qos_pkg::CMD_PUSH: begin
        if (work_fill_q >= FILL_MAX) begin
          status_d = qos_pkg::STS_FULL;
        end else begin
          word_we     = 1'b1;
          work_fill_d = work_fill_q + FW'(1);
        end
      end
      qos_pkg::CMD_POP: begin
        if (work_fill_q == '0) begin
          status_d = qos_pkg::STS_STACK_EMPTY;
        end else begin
          work_fill_d = work_fill_q - FW'(1);
          popped_d    = word_sx[VW-1:0];
        end
      end
      qos_pkg::CMD_PARK: begin
        if (free_q == '0) begin
          status_d = qos_pkg::STS_FULL;
        end else begin
          ring_we       = 1'b1;
          count_d       = count_q + CW'(1);
          free_d[fresh] = 1'b0;
          work_slot_d   = fresh;
          work_fill_d   = '0;
        end
      end
      qos_pkg::CMD_TAKE: begin
        if (count_q == '0) begin
          status_d = qos_pkg::STS_QUEUE_EMPTY;
        end else begin
          free_d[work_slot_q] = 1'b1;
          work_slot_d = rd_slot_q;
          work_fill_d = rd_fill_q;
          head_d      = (head_q == HEAD_LAST) ? '0 : head_q + CW'(1);
          count_d     = count_q - CW'(1);
        end
      end
      default: status_d = qos_pkg::STS_OK;
    endcase
  end

  assign size_ext = {{qos_pkg::SIZE_W{1'b0}}, work_fill_d};
  assign qlen_ext = {{qos_pkg::QLEN_W{1'b0}}, count_d};

  // Pointer and map state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_slot_q <= '0;
      work_fill_q <= '0;
      head_q      <= '0;
      count_q     <= '0;
      free_q      <= {{(NUM_SLOTS - 1){1'b1}}, 1'b0};
    end else if (ctl_i.execute) begin
      work_slot_q <= work_slot_d;
      work_fill_q <= work_fill_d;
      head_q      <= head_d;
      count_q     <= count_d;
      free_q      <= free_d;
    end
  end

  // Transaction capture and result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q   <= cmd_i;
      value_q <= value_i;
    end
    if (ctl_i.execute) begin
      status_q <= status_d;
      popped_q <= popped_d;
      size_q   <= size_ext[qos_pkg::SIZE_W-1:0];
      qlen_q   <= qlen_ext[qos_pkg::QLEN_W-1:0];
    end
  end

  // Slot word memory: read at capture, write at execute
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) rd_word_q <= words_mem[work_slot_q][rd_idx];
    if (ctl_i.execute && word_we) begin
      words_mem[work_slot_q][work_fill_q[DIW-1:0]] <= value_ext[DATA_WIDTH-1:0];
    end
  end

  // Queue ring memory: head read at capture, tail write at execute
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      rd_slot_q <= ring_slot_mem[head_q];
      rd_fill_q <= ring_fill_mem[head_q];
    end
    if (ctl_i.execute && ring_we) begin
      ring_slot_mem[tail] <= work_slot_q;
      ring_fill_mem[tail] <= work_fill_q;
    end
  end

  assign status_o       = status_q;
  assign popped_value_o = $signed(popped_q);
  assign stack_size_o   = size_q;
  assign queue_length_o = qlen_q;

endmodule

### rtl/queue_of_stacks_manager.sv
// Queue of stacks manager: a working stack plus a FIFO of parked stacks in a slot pool.
//
// Usage: commands arrive on req_i (cmd, value) and each produces exactly one
// response on rsp_o (status, popped_value, stack_size, queue_length). Both
// channels move a transaction when valid and ready are high at a clock edge.
// Commands: push value, pop the top word, park the working stack at the queue
// tail and open an empty stack in the lowest free slot, or take the queue head
// as the working stack and return the old working slot to the pool.
// Timing: a command is accepted in the idle state, where the slot memory and
// queue ring are read into registers; it completes in the execute state, which
// loads the response register. No new command is taken until it has executed.
// Stall: the response sits in an output register; the next command is still
// accepted, and it waits in its execute cycle until the response is taken.
// Reset: working stack empty in slot zero, queue empty, all other slots free.
// No memory clearing is needed; the block accepts commands right after reset.
`timescale 1ns / 1ps

module queue_of_stacks_manager #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned NUM_SLOTS   = 8,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qos_req_if.sink   req_i,
  qos_rsp_if.source rsp_o
);

  qos_pkg::ctl_t ctl;

  qos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .ctl_o       (ctl)
  );

  qos_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .NUM_SLOTS   (NUM_SLOTS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .cmd_i          (req_i.cmd),
    .value_i        (req_i.value),
    .status_o       (rsp_o.status),
    .popped_value_o (rsp_o.popped_value),
    .stack_size_o   (rsp_o.stack_size),
    .queue_length_o (rsp_o.queue_length)
  );

endmodule
